// ===== hw/rtl/pfb_pkg.sv =====
package pfb_pkg;

  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_IMAGE = 2'd1;
  localparam logic [1:0] REQ_FILL  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_TOGGLE = 2'd2;
  localparam logic [1:0] MODE_KEEP   = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FILL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch a new item
    logic rd_en;       // read the addressed word
    logic wr_en;       // merge and write the addressed word
    logic set_second;  // move on to the extra final page
    logic sweep;       // write one word of a fill or clearing pass
    logic sweep_zero;  // clearing pass writes zero
    logic done;        // present the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_req;
    logic need_second;
    logic sweep_last;
  } status_t;

  // rows [off, off+h) that fall into relative page k
  function automatic logic [7:0] page_mask(input logic [2:0] off, input logic [6:0] h,
                                           input logic [4:0] k);
    logic [7:0] m;
    logic [8:0] pos;
    logic [8:0] lo;
    logic [8:0] hi;
    m  = 8'd0;
    lo = {6'd0, off};
    hi = {6'd0, off} + {2'd0, h};
    for (int b = 0; b < 8; b++) begin
      pos  = {1'b0, k, 3'd0} + 9'(b);
      m[b] = (pos >= lo) && (pos < hi);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/pfb_ctrl.sv =====
module pfb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pfb_pkg::status_t  status_i,
  output pfb_pkg::cmd_t     cmd_o,
  output logic              busy_o
);

  pfb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfb_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      pfb_pkg::ST_CLEAR: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_zero = 1'b1;
        if (status_i.sweep_last) begin
          state_d = pfb_pkg::ST_IDLE;
        end
      end
      pfb_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.fill_req ? pfb_pkg::ST_FILL : pfb_pkg::ST_READ;
        end
      end
      pfb_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = pfb_pkg::ST_WRITE;
      end
      pfb_pkg::ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.need_second) begin
          cmd_o.set_second = 1'b1;
          state_d          = pfb_pkg::ST_READ;
        end else begin
          cmd_o.done = 1'b1;
          state_d    = pfb_pkg::ST_IDLE;
        end
      end
      pfb_pkg::ST_FILL: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          cmd_o.done = 1'b1;
          state_d    = pfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfb_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pfb_datapath.sv =====
module pfb_datapath #(
  parameter int COLUMNS = 96,
  parameter int PAGES   = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfb_pkg::cmd_t     cmd_i,
  output pfb_pkg::status_t  status_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [1:0]        req_type_i,
  input  logic [6:0]        x_pos_i,
  input  logic [6:0]        y_pos_i,
  input  logic [1:0]        pixel_mode_i,
  input  logic [7:0]        image_byte_i,
  input  logic [6:0]        column_index_i,
  input  logic [3:0]        byte_row_i,
  input  logic [6:0]        img_height_i,
  input  logic [7:0]        fill_value_i,
  input  logic [10:0]       word_index_i,
  output logic [7:0]        read_data_o,
  output logic              dropped_o,
  output logic              done_o
);

  localparam int Words = COLUMNS * PAGES;
  localparam int AW    = $clog2(Words);
  localparam int CW    = $clog2(COLUMNS);

  logic [7:0] mem_q [Words];
  logic [7:0] rdata_q;

  logic [1:0]  req_q;
  logic [6:0]  x_q;
  logic [6:0]  y_q;
  logic [1:0]  mode_q;
  logic [7:0]  img_q;
  logic [6:0]  ci_q;
  logic [3:0]  row_q;
  logic [6:0]  h_q;
  logic [7:0]  fill_q;
  logic [10:0] widx_q;

  logic          second_q;
  logic          drop_q;
  logic [7:0]    carry_q;
  logic          mirror_q;
  logic [AW-1:0] cnt_q;
  logic          done_q;
  logic [7:0]    read_data_q;
  logic          dropped_q;

  logic          is_pixel, is_image, is_read;
  logic [2:0]    off;
  logic [6:0]    h_m1;
  logic          img_valid;
  logic [4:0]    page_sum;
  logic [7:0]    col_raw;
  logic [8:0]    col_mir;
  logic [CW-1:0] col;
  logic          col_ok, page_ok, tgt_ok, rd_ok;
  logic [AW-1:0] item_addr, addr;
  logic [15:0]   acc;
  logic [4:0]    mask_page;
  logic [7:0]    mask;
  logic [7:0]    pix_bit;
  logic [7:0]    pix_word;
  logic [7:0]    img_data;
  logic [7:0]    merged;
  logic          need_second_raw;
  logic          item_we, cur_drop;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  assign is_pixel = (req_q == pfb_pkg::REQ_PIXEL);
  assign is_image = (req_q == pfb_pkg::REQ_IMAGE);
  assign is_read  = (req_q == pfb_pkg::REQ_READ);

  assign off       = y_q[2:0];
  assign h_m1      = h_q - 7'd1;
  assign img_valid = (h_q != 7'd0) && (row_q <= h_m1[6:3]);

  // pixel goes to its own page, image bytes to top page plus byte row (plus one on the extra page)
  assign page_sum = is_pixel ? {1'b0, y_q[6:3]}
                             : {1'b0, y_q[6:3]} + {1'b0, row_q} + {4'd0, second_q};
  assign col_raw  = is_pixel ? {1'b0, x_q} : {1'b0, x_q} + {1'b0, ci_q};
  assign col_mir  = 9'(COLUMNS - 1) - {1'b0, col_raw};
  assign col      = mirror_q ? col_mir[CW-1:0] : col_raw[CW-1:0];
  assign col_ok   = {1'b0, col_raw} < 9'(COLUMNS);
  assign page_ok  = page_sum < 5'(PAGES);
  assign tgt_ok   = col_ok && page_ok;
  assign rd_ok    = 32'(widx_q) < Words;

  assign item_addr = AW'(32'(page_sum) * COLUMNS + 32'(col));
  assign addr      = is_read ? AW'(widx_q) : item_addr;

  assign acc       = ((row_q == 4'd0) ? 16'd0 : {8'd0, carry_q}) | ({8'd0, img_q} << off);
  assign mask_page = {1'b0, row_q} + {4'd0, second_q};
  assign mask      = pfb_pkg::page_mask(off, h_q, mask_page);

  assign need_second_raw = is_image && img_valid && (row_q == h_m1[6:3]) &&
                           (({5'd0, off} + {1'b0, h_q}) > (({4'd0, row_q} + 8'd1) << 3));

  assign pix_bit = 8'h01 << off;

  always_comb begin
    case (mode_q)
      pfb_pkg::MODE_CLEAR:  pix_word = rdata_q & ~pix_bit;
      pfb_pkg::MODE_SET:    pix_word = rdata_q | pix_bit;
      pfb_pkg::MODE_TOGGLE: pix_word = rdata_q ^ pix_bit;
      pfb_pkg::MODE_KEEP:   pix_word = rdata_q;
      default:              pix_word = rdata_q;
    endcase
  end

  // carry_q already holds the spilled bits when the extra page is written
  assign img_data = second_q ? carry_q : acc[7:0];
  assign merged   = is_pixel ? pix_word : ((rdata_q & ~mask) | (img_data & mask));

  assign item_we  = cmd_i.wr_en && tgt_ok && (is_pixel || (is_image && img_valid));
  assign cur_drop = cmd_i.wr_en && (((is_pixel || (is_image && img_valid)) && !tgt_ok) ||
                                    (is_read && !rd_ok));

  assign mem_we = cmd_i.sweep || item_we;
  assign waddr  = cmd_i.sweep ? cnt_q : addr;
  assign wdata  = cmd_i.sweep ? (cmd_i.sweep_zero ? 8'd0 : fill_q) : merged;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      x_q    <= x_pos_i;
      y_q    <= y_pos_i;
      mode_q <= pixel_mode_i;
      img_q  <= image_byte_i;
      ci_q   <= column_index_i;
      row_q  <= byte_row_i;
      h_q    <= img_height_i;
      fill_q <= fill_value_i;
      widx_q <= word_index_i;
    end
    if (cmd_i.done) begin
      read_data_q <= (is_read && rd_ok) ? rdata_q : 8'd0;
      dropped_q   <= drop_q | cur_drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
      drop_q   <= 1'b0;
      carry_q  <= 8'd0;
      mirror_q <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.done;
      if (cfg_we_i) begin
        mirror_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        second_q <= 1'b0;
        drop_q   <= 1'b0;
        cnt_q    <= '0;
      end else begin
        if (cmd_i.set_second) begin
          second_q <= 1'b1;
        end
        if (cur_drop) begin
          drop_q <= 1'b1;
        end
        if (cmd_i.sweep) begin
          cnt_q <= cnt_q + AW'(1);
        end
      end
      if (cmd_i.wr_en && is_image && img_valid && !second_q) begin
        carry_q <= acc[15:8];
      end
    end
  end

  assign status_o.fill_req    = (req_type_i == pfb_pkg::REQ_FILL);
  assign status_o.need_second = need_second_raw && !second_q;
  assign status_o.sweep_last  = (32'(cnt_q) == Words - 1);

  assign read_data_o = read_data_q;
  assign dropped_o   = dropped_q;
  assign done_o      = done_q;

endmodule

// ===== hw/rtl/page_framebuffer_pixel_and_blit.sv =====
// channel   ports                                         handshake
// request   req_type_i .. word_index_i                    start_i & !busy_o
// result    read_data_o, dropped_o                        done_o, one cycle
// config    cfg_wdata_i                                   cfg_we_i
//
// pixel, read and single-page image byte requests go through the read and the
// merge-and-write state before done_o; an image byte that also writes the next
// page goes through both twice. the frame store has one port pair, so each word
// needs a read and a merge-and-write step. fill writes every word, one per cycle.
// after reset the store is cleared with busy_o high. results cannot be stalled.
module page_framebuffer_pixel_and_blit #(
  parameter int COLUMNS = 96,
  parameter int PAGES   = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [6:0]  x_pos_i,
  input  logic [6:0]  y_pos_i,
  input  logic [1:0]  pixel_mode_i,
  input  logic [7:0]  image_byte_i,
  input  logic [6:0]  column_index_i,
  input  logic [3:0]  byte_row_i,
  input  logic [6:0]  img_height_i,
  input  logic [7:0]  fill_value_i,
  input  logic [10:0] word_index_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        dropped_o
);

  pfb_pkg::cmd_t    cmd;
  pfb_pkg::status_t status;

  pfb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  pfb_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .pixel_mode_i   (pixel_mode_i),
    .image_byte_i   (image_byte_i),
    .column_index_i (column_index_i),
    .byte_row_i     (byte_row_i),
    .img_height_i   (img_height_i),
    .fill_value_i   (fill_value_i),
    .word_index_i   (word_index_i),
    .read_data_o    (read_data_o),
    .dropped_o      (dropped_o),
    .done_o         (done_o)
  );

  // an accepted item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  // result shows up only once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result while still busy");

  // nonzero read data never comes with a drop
  a_data_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (read_data_o != 8'd0)) |-> !dropped_o)
    else $error("dropped item carries read data");

  // an item read, write, carry update or load never overlaps a sweep
  a_sweep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep |-> !(cmd.wr_en || cmd.rd_en || cmd.load))
    else $error("sweep overlaps item access");

endmodule
